FILE: sv/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  localparam int MEM_UNITS_DEF  = 1024;
  localparam int OWNER_BITS_DEF = 16;

  localparam int ACTION_W = 1;
  localparam int REQ_W    = 11;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int START_W  = 10;
  localparam int SIZE_W   = 11;
  // Rounded request size can reach 2048.
  localparam int NEED_W   = REQ_W + 1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_RD,
    OP_EV_BEST,
    OP_SPLIT,
    OP_COMMIT,
    OP_NOSPACE,
    OP_EV_OWN,
    OP_NOBLOCK,
    OP_RELEASE,
    OP_MRG_EV,
    OP_MRG_W1,
    OP_MRG_W2,
    OP_MRG_NEXT,
    OP_PUSH
  } bba_op_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_A_DEC,
    S_F_RD,
    S_F_EV,
    S_F_REL,
    S_M_RD,
    S_M_EV,
    S_M_CMP,
    S_M_W2,
    S_FIN
  } bba_state_t;

  typedef struct packed {
    bba_op_t op;
  } bba_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic is_free;
    logic fits;
    logic best_zero;
    logic split_more;
    logic cand;
    logic mate_eq;
    logic match;
    logic changed;
    logic out_busy;
  } bba_stat_t;

endpackage
`default_nettype wire

FILE: sv/bba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      out_ready,
  input  wire bba_stat_t stat,
  output bba_cmd_t       cmd
);

  bba_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.op = OP_CLEAR;
        if (stat.scan_end) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = stat.is_free ? S_F_RD : S_A_RD;
        end
      end
      S_A_RD: begin
        if (!stat.fits) begin
          cmd.op    = OP_NOSPACE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_A_EV;
        end
      end
      S_A_EV: begin
        cmd.op    = OP_EV_BEST;
        state_nxt = stat.scan_end ? S_A_DEC : S_A_RD;
      end
      S_A_DEC: begin
        if (stat.best_zero) begin
          cmd.op    = OP_NOSPACE;
          state_nxt = S_FIN;
        end else if (stat.split_more) begin
          cmd.op = OP_SPLIT;
        end else begin
          cmd.op    = OP_COMMIT;
          state_nxt = S_FIN;
        end
      end
      S_F_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_F_EV;
      end
      S_F_EV: begin
        if (stat.match) begin
          cmd.op    = OP_EV_OWN;
          state_nxt = S_F_REL;
        end else if (stat.scan_end) begin
          cmd.op    = OP_NOBLOCK;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_EV_OWN;
          state_nxt = S_F_RD;
        end
      end
      S_F_REL: begin
        cmd.op    = OP_RELEASE;
        state_nxt = S_M_RD;
      end
      S_M_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_M_EV;
      end
      S_M_EV: begin
        if (stat.cand) begin
          cmd.op    = OP_MRG_EV;
          state_nxt = S_M_CMP;
        end else begin
          cmd.op    = OP_MRG_NEXT;
          state_nxt = (stat.scan_end && !stat.changed) ? S_FIN : S_M_RD;
        end
      end
      S_M_CMP: begin
        if (stat.mate_eq) begin
          cmd.op    = OP_MRG_W1;
          state_nxt = S_M_W2;
        end else begin
          cmd.op    = OP_MRG_NEXT;
          state_nxt = (stat.scan_end && !stat.changed) ? S_FIN : S_M_RD;
        end
      end
      S_M_W2: begin
        // A merge always forces another pass.
        cmd.op    = OP_MRG_W2;
        state_nxt = S_M_RD;
      end
      S_FIN: begin
        if (!stat.out_busy || out_ready) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/bba_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module bba_dp
  import bba_pkg::*;
#(
  parameter int MEM_UNITS  = MEM_UNITS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [REQ_W-1:0]    in_request_size,
  input  wire logic [ID_W-1:0]     in_owner_id,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [START_W-1:0]       out_block_start,
  output logic [SIZE_W-1:0]        out_block_size,
  input  wire bba_cmd_t            cmd,
  output bba_stat_t                stat
);

  localparam int AW = $clog2(MEM_UNITS);
  localparam int SW = AW + 1;
  localparam int OW = OWNER_BITS + 1;
  localparam logic [SW-1:0] FULL = SW'(MEM_UNITS);

  logic [SW-1:0] free_mem [MEM_UNITS];
  logic [OW-1:0] own_mem  [MEM_UNITS];
  logic [SW-1:0] held_mem [MEM_UNITS];

  logic [SW-1:0] free_rd_r, held_rd_r;
  logic [OW-1:0] own_rd_r;

  logic [AW-1:0]         idx_r, idx_nxt;
  logic [NEED_W-1:0]     need_r, need_nxt;
  logic [OWNER_BITS-1:0] key_r, key_nxt;
  logic [SW-1:0]         best_r, best_nxt;
  logic [AW-1:0]         best_at_r, best_at_nxt;
  logic [SW-1:0]         s_r, s_nxt;
  logic                  changed_r, changed_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [AW-1:0]         res_start_r, res_start_nxt;
  logic [SW-1:0]         res_size_r, res_size_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [AW-1:0]         out_start_r, out_start_nxt;
  logic [SW-1:0]         out_size_r, out_size_nxt;

  logic                  free_we, oh_we;
  logic [AW-1:0]         free_wa, oh_wa, free_ra;
  logic [SW-1:0]         free_wd, held_wd;
  logic [OW-1:0]         own_wd;

  logic [NEED_W-1:0]     need_calc;
  logic [SW-1:0]         mate, half, split_at;
  logic                  take, scan_end;

  // Smallest power of two not below the request; zero counts as one.
  always_comb begin
    need_calc = NEED_W'(1);
    for (int k = NEED_W - 1; k >= 0; k--) begin
      if ((32'd1 << k) >= 32'(in_request_size)) need_calc = NEED_W'(32'd1 << k);
    end
  end

  assign scan_end = (idx_r == AW'(MEM_UNITS - 1));
  assign mate     = {1'b0, idx_r} + free_rd_r;
  assign half     = best_r >> 1;
  assign split_at = {1'b0, best_at_r} + half;
  assign take     = (32'(free_rd_r) >= 32'(need_r)) &&
                    ((best_r == '0) || (free_rd_r < best_r));

  always_comb begin
    stat.scan_end   = scan_end;
    stat.is_free    = (in_action == ACT_FREE);
    stat.fits       = (32'(need_r) <= 32'(MEM_UNITS));
    stat.best_zero  = (best_r == '0);
    stat.split_more = (32'(best_r) > 32'(need_r));
    // Free block whose start is aligned to twice its size, with a buddy in range.
    stat.cand       = (free_rd_r != '0) && ((({1'b0, idx_r}) & free_rd_r) == '0) &&
                      (mate < FULL);
    stat.mate_eq    = (free_rd_r == s_r);
    stat.match      = own_rd_r[OWNER_BITS] && (own_rd_r[OWNER_BITS-1:0] == key_r);
    stat.changed    = changed_r;
    stat.out_busy   = out_valid_r;
  end

  always_comb begin
    idx_nxt        = idx_r;
    need_nxt       = need_r;
    key_nxt        = key_r;
    best_nxt       = best_r;
    best_at_nxt    = best_at_r;
    s_nxt          = s_r;
    changed_nxt    = changed_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_size_nxt   = res_size_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_size_nxt   = out_size_r;
    free_we        = 1'b0;
    free_wa        = idx_r;
    free_wd        = '0;
    oh_we          = 1'b0;
    oh_wa          = idx_r;
    own_wd         = '0;
    held_wd        = '0;
    free_ra        = idx_r;
    unique case (cmd.op)
      OP_NONE: ;
      OP_CLEAR: begin
        free_we = 1'b1;
        free_wd = (idx_r == '0) ? FULL : '0;
        oh_we   = 1'b1;
        idx_nxt = idx_r + AW'(1);
      end
      OP_LOAD: begin
        need_nxt    = need_calc;
        key_nxt     = OWNER_BITS'(in_owner_id);
        best_nxt    = '0;
        best_at_nxt = '0;
        idx_nxt     = '0;
      end
      OP_RD: ;
      OP_EV_BEST: begin
        if (take) begin
          best_nxt    = free_rd_r;
          best_at_nxt = idx_r;
        end
        idx_nxt = idx_r + AW'(1);
      end
      OP_SPLIT: begin
        best_nxt = half;
        free_we  = (split_at < FULL);
        free_wa  = split_at[AW-1:0];
        free_wd  = half;
      end
      OP_COMMIT: begin
        free_we        = 1'b1;
        free_wa        = best_at_r;
        free_wd        = '0;
        oh_we          = 1'b1;
        oh_wa          = best_at_r;
        own_wd         = {1'b1, key_r};
        held_wd        = SW'(need_r);
        res_status_nxt = ST_DONE;
        res_start_nxt  = best_at_r;
        res_size_nxt   = SW'(need_r);
      end
      OP_NOSPACE: begin
        res_status_nxt = ST_NO_SPACE;
        res_start_nxt  = '0;
        res_size_nxt   = '0;
      end
      OP_EV_OWN: begin
        if (stat.match) begin
          res_status_nxt = ST_DONE;
          res_start_nxt  = idx_r;
          res_size_nxt   = held_rd_r;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      OP_NOBLOCK: begin
        res_status_nxt = ST_NO_BLOCK;
        res_start_nxt  = '0;
        res_size_nxt   = '0;
      end
      OP_RELEASE: begin
        free_we     = 1'b1;
        free_wa     = res_start_r;
        free_wd     = res_size_r;
        oh_we       = 1'b1;
        oh_wa       = res_start_r;
        idx_nxt     = '0;
        changed_nxt = 1'b0;
      end
      OP_MRG_EV: begin
        s_nxt   = free_rd_r;
        free_ra = mate[AW-1:0];
        best_at_nxt = mate[AW-1:0];
      end
      OP_MRG_W1: begin
        free_we = 1'b1;
        free_wa = best_at_r;
        free_wd = '0;
      end
      OP_MRG_W2: begin
        free_we     = 1'b1;
        free_wa     = idx_r;
        free_wd     = s_r << 1;
        idx_nxt     = idx_r + AW'(1);
        changed_nxt = !scan_end;
      end
      OP_MRG_NEXT: begin
        idx_nxt = idx_r + AW'(1);
        if (scan_end) changed_nxt = 1'b0;
      end
      OP_PUSH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status_r;
        out_start_nxt  = res_start_r;
        out_size_nxt   = res_size_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd_r <= free_mem[free_ra];
  end

  always_ff @(posedge clk) begin
    if (oh_we) begin
      own_mem[oh_wa]  <= own_wd;
      held_mem[oh_wa] <= held_wd;
    end
    own_rd_r  <= own_mem[idx_r];
    held_rd_r <= held_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      changed_r   <= changed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r       <= need_nxt;
    key_r        <= key_nxt;
    best_r       <= best_nxt;
    best_at_r    <= best_at_nxt;
    s_r          <= s_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_size_r   <= res_size_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_size_r   <= out_size_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_start = START_W'(out_start_r);
  assign out_block_size  = SIZE_W'(out_size_r);

endmodule
`default_nettype wire

FILE: sv/buddy_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Ports
// input     in         in_valid, in_ready, in_action, in_request_size, in_owner_id
// result    out        out_valid, out_ready, out_status, out_block_start, out_block_size
//
// One request at a time. An allocate scans the free table, reading and then
// evaluating each entry, and then halves the chosen block one cycle per level.
// A free scans the owner table, reading and then checking each entry, then runs
// merge passes that read, evaluate and merge buddies until a pass merges nothing.
// After reset a clearing pass over every entry runs before the first beat is taken.
// A finished result sits in the output register while the next beat may be accepted.
module buddy_block_allocator_top
  import bba_pkg::*;
#(
  parameter int MEM_UNITS  = MEM_UNITS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [REQ_W-1:0]    in_request_size,
  input  wire logic [ID_W-1:0]     in_owner_id,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [START_W-1:0]       out_block_start,
  output logic [SIZE_W-1:0]        out_block_size
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp #(
    .MEM_UNITS (MEM_UNITS),
    .OWNER_BITS(OWNER_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_request_size(in_request_size),
    .in_owner_id    (in_owner_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_block_start(out_block_start),
    .out_block_size (out_block_size),
    .cmd            (cmd),
    .stat           (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second beat while busy");

  a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_PUSH |-> (!out_valid || out_ready))
    else $error("result pushed over an untaken beat");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_block_start == '0 && out_block_size == '0)
    else $error("error result with nonzero block");

endmodule
`default_nettype wire
